// ===== rtl/npi_pkg.sv =====
// Shared types and constants for the Newton polynomial interpolator.
package npi_pkg;

    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // Command codes carried in the func field
    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUP   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_DROP  = 2'd3;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD0,
        ST_ROW_LD,
        ST_TERM,
        ST_ACC,
        ST_CUPD,
        ST_DIV_CHK,
        ST_DIV_RUN,
        ST_COEF,
        ST_MULC,
        ST_FX,
        ST_PUPD,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/npi_cmd_if.sv =====
// Command channel: store a sample point or evaluate at a query position.
interface npi_cmd_if;
    logic                                valid;
    logic                                ready;
    logic                                func;
    logic signed [npi_pkg::DATA_W-1:0]   point_x;
    logic signed [npi_pkg::DATA_W-1:0]   point_y;
    logic signed [npi_pkg::DATA_W-1:0]   query_x;

    modport source (output valid, func, point_x, point_y, query_x, input ready);
    modport sink   (input valid, func, point_x, point_y, query_x, output ready);
endinterface

// ===== rtl/npi_res_if.sv =====
// Result channel: interpolated value and status.
interface npi_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [npi_pkg::DATA_W-1:0]   value;
    logic [npi_pkg::STATUS_W-1:0]        status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

// ===== rtl/newton_polynomial_interpolator_unit.sv =====
// Store item: accepted while the unit is idle. Evaluate item over n points:
//   its run is set by the shared multiplier walking each row and the
//   one-bit-a-cycle divider.
// One item is worked at a time; a finished result waits in the output
//   register while store transactions are still taken.
// Reset clears the point count, drop flag and handshakes; the point and
//   coefficient memories hold no reset value and need no clearing pass.
module newton_polynomial_interpolator_unit #(
    parameter int MAX_POINTS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    npi_cmd_if.sink   cmd,
    npi_res_if.source res
);
    import npi_pkg::*;

    localparam int IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int DW  = DATA_W + FRAC_BITS;
    localparam int DCW = $clog2(DW + 1);
    localparam logic signed [DATA_W-1:0] FX_ONE = DATA_W'(1) << FRAC_BITS;

    // Saturating fixed-point helpers
    function automatic logic signed [DATA_W-1:0] fx_sat33(input logic signed [DATA_W:0] v);
        if (v[DATA_W] != v[DATA_W-1])
            return v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] fx_add(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        return fx_sat33(s);
    endfunction

    function automatic logic signed [DATA_W-1:0] fx_sub(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        return fx_sat33(s);
    endfunction

    // Round half up, floor shift, saturate a full product
    function automatic logic signed [DATA_W-1:0] fx_rnd(input logic signed [2*DATA_W-1:0] p);
        logic signed [2*DATA_W-1:0] t;
        logic signed [2*DATA_W-1:0] s;
        t = p + ((2*DATA_W)'(1) << (FRAC_BITS - 1));
        s = t >>> FRAC_BITS;
        if (s > $signed(64'h0000_0000_7FFF_FFFF))
            return {1'b0, {(DATA_W-1){1'b1}}};
        if (s < $signed(64'hFFFF_FFFF_8000_0000))
            return {1'b1, {(DATA_W-1){1'b0}}};
        return s[DATA_W-1:0];
    endfunction

    // Memories
    logic [2*DATA_W-1:0] pt_mem [MAX_POINTS];
    logic [DATA_W-1:0]   coef_mem [MAX_POINTS];
    logic [2*DATA_W-1:0] pt_q_reg;
    logic [DATA_W-1:0]   coef_q_reg;
    logic                pt_we, coef_we;
    logic [IW-1:0]       pt_waddr, pt_raddr, coef_waddr, coef_raddr;
    logic [2*DATA_W-1:0] pt_wdata;
    logic [DATA_W-1:0]   coef_wdata;

    // Control state
    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           ovf_reg, ovf_next;
    logic           ovf_hold_reg, ovf_hold_next;
    logic [CW-1:0]  n_reg, n_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [CW-1:0]  j_reg, j_next;
    logic [DCW-1:0] div_cnt_reg, div_cnt_next;
    logic           out_valid_reg, out_valid_next;

    // Datapath
    logic signed [DATA_W-1:0]   q_reg, q_next;
    logic signed [DATA_W-1:0]   xi_reg, xi_next;
    logic signed [DATA_W-1:0]   yi_reg, yi_next;
    logic signed [DATA_W-1:0]   acc_reg, acc_next;
    logic signed [DATA_W-1:0]   c_reg, c_next;
    logic signed [DATA_W-1:0]   d_reg, d_next;
    logic signed [DATA_W-1:0]   fx_reg, fx_next;
    logic signed [DATA_W-1:0]   p_reg, p_next;
    logic signed [DATA_W-1:0]   coef_reg, coef_next;
    logic signed [DATA_W-1:0]   res_value_reg, res_value_next;
    logic [STATUS_W-1:0]        res_status_reg, res_status_next;
    logic signed [DATA_W-1:0]   out_value_reg, out_value_next;
    logic [STATUS_W-1:0]        out_status_reg, out_status_next;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [DATA_W-1:0]   mul_a, mul_b;

    // Divider
    logic [DATA_W:0]   div_rem_reg, div_rem_next;
    logic [DW-1:0]     div_dq_reg, div_dq_next;
    logic [DATA_W-1:0] div_dv_reg, div_dv_next;
    logic              div_neg_reg, div_neg_next;
    logic [DATA_W:0]   rem_sh, rem_diff;
    logic              rem_ge;
    logic signed [DATA_W-1:0] div_sat;
    logic signed [DATA_W-1:0] num;
    logic [DATA_W-1:0] num_mag, den_mag;

    logic signed [DATA_W-1:0] pt_qx, pt_qy;
    logic cmd_fire, out_load;

    assign cmd.ready  = (state_reg == ST_IDLE);
    assign cmd_fire   = cmd.valid & cmd.ready;
    assign out_load   = (state_reg == ST_DONE) && (!out_valid_reg || res.ready);
    assign res.valid  = out_valid_reg;
    assign res.value  = out_value_reg;
    assign res.status = out_status_reg;
    assign pt_qx      = pt_q_reg[2*DATA_W-1:DATA_W];
    assign pt_qy      = pt_q_reg[DATA_W-1:0];

    // Divider step and final saturation
    assign rem_sh   = {div_rem_reg[DATA_W-1:0], div_dq_reg[DW-1]};
    assign rem_diff = rem_sh - {1'b0, div_dv_reg};
    assign rem_ge   = (rem_sh >= {1'b0, div_dv_reg});

    always_comb
    begin
        if (div_neg_reg)
        begin
            if (div_dq_reg[DW-1:DATA_W] != '0 ||
                (div_dq_reg[DATA_W-1] && div_dq_reg[DATA_W-2:0] != '0))
                div_sat = {1'b1, {(DATA_W-1){1'b0}}};
            else
                div_sat = -$signed(div_dq_reg[DATA_W-1:0]);
        end
        else
        begin
            if (div_dq_reg[DW-1:DATA_W-1] != '0)
                div_sat = {1'b0, {(DATA_W-1){1'b1}}};
            else
                div_sat = $signed(div_dq_reg[DATA_W-1:0]);
        end
    end

    // Divider operands
    assign num     = fx_sub(yi_reg, acc_reg);
    assign num_mag = num[DATA_W-1] ? (~num + DATA_W'(1)) : num;
    assign den_mag = c_reg[DATA_W-1] ? (~c_reg + DATA_W'(1)) : c_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && cmd.func == FUNC_EVAL)
                    state_next = (count_reg == '0) ? ST_DONE : ST_LD0;
            end
            ST_LD0:     state_next = (n_reg == CW'(1)) ? ST_DONE : ST_ROW_LD;
            ST_ROW_LD:  state_next = ST_TERM;
            ST_TERM:    state_next = ST_ACC;
            ST_ACC:     state_next = ST_CUPD;
            ST_CUPD:    state_next = (CW'(j_reg + 1'b1) == i_reg) ? ST_DIV_CHK : ST_TERM;
            ST_DIV_CHK: state_next = (c_reg == '0) ? ST_DONE : ST_DIV_RUN;
            ST_DIV_RUN: state_next = (div_cnt_reg == DCW'(1)) ? ST_COEF : ST_DIV_RUN;
            ST_COEF:    state_next = ST_MULC;
            ST_MULC:    state_next = ST_FX;
            ST_FX:      state_next = ST_PUPD;
            ST_PUPD:    state_next = (CW'(i_reg + 1'b1) == n_reg) ? ST_DONE : ST_ROW_LD;
            ST_DONE:    state_next = out_load ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        ovf_hold_next   = ovf_hold_reg;
        n_next          = n_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        div_cnt_next    = div_cnt_reg;
        q_next          = q_reg;
        xi_next         = xi_reg;
        yi_next         = yi_reg;
        acc_next        = acc_reg;
        c_next          = c_reg;
        d_next          = d_reg;
        fx_next         = fx_reg;
        p_next          = p_reg;
        coef_next       = coef_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        div_rem_next    = div_rem_reg;
        div_dq_next     = div_dq_reg;
        div_dv_next     = div_dv_reg;
        div_neg_next    = div_neg_reg;
        pt_we           = 1'b0;
        pt_waddr        = count_reg[IW-1:0];
        pt_wdata        = {cmd.point_x, cmd.point_y};
        coef_we         = 1'b0;
        coef_waddr      = i_reg[IW-1:0];
        coef_wdata      = div_sat;
        pt_raddr        = '0;
        coef_raddr      = '0;
        mul_a           = coef_q_reg;
        mul_b           = c_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd.func == FUNC_STORE)
                    begin
                        if (count_reg < CW'(MAX_POINTS))
                        begin
                            pt_we      = 1'b1;
                            count_next = CW'(count_reg + 1'b1);
                        end
                        else
                            ovf_next = 1'b1;
                    end
                    else
                    begin
                        q_next          = cmd.query_x;
                        n_next          = count_reg;
                        ovf_hold_next   = ovf_reg;
                        count_next      = '0;
                        ovf_next        = 1'b0;
                        res_value_next  = '0;
                        res_status_next = STATUS_EMPTY;
                    end
                end
            end
            // First point: coefficient is its ordinate
            ST_LD0:
            begin
                coef_we         = 1'b1;
                coef_waddr      = '0;
                coef_wdata      = pt_qy;
                fx_next         = pt_qy;
                p_next          = fx_sub(q_reg, pt_qx);
                i_next          = CW'(1);
                res_value_next  = pt_qy;
                res_status_next = ovf_hold_reg ? STATUS_DROP : STATUS_OK;
                pt_raddr        = IW'(1);
            end
            ST_ROW_LD:
            begin
                xi_next  = pt_qx;
                yi_next  = pt_qy;
                acc_next = '0;
                c_next   = FX_ONE;
                j_next   = '0;
            end
            // Term j: coefficient times running product of differences
            ST_TERM:
            begin
                mul_a  = $signed(coef_q_reg);
                mul_b  = c_reg;
                d_next = fx_sub(xi_reg, pt_qx);
            end
            ST_ACC:
            begin
                acc_next = fx_add(acc_reg, fx_rnd(prod_reg));
                mul_a    = c_reg;
                mul_b    = d_reg;
            end
            ST_CUPD:
            begin
                c_next     = fx_rnd(prod_reg);
                j_next     = CW'(j_reg + 1'b1);
                pt_raddr   = j_next[IW-1:0];
                coef_raddr = j_next[IW-1:0];
            end
            // Running product is the divisor
            ST_DIV_CHK:
            begin
                if (c_reg == '0)
                begin
                    res_value_next  = '0;
                    res_status_next = STATUS_DUP;
                end
                else
                begin
                    div_rem_next = '0;
                    div_dq_next  = {num_mag, {FRAC_BITS{1'b0}}};
                    div_dv_next  = den_mag;
                    div_neg_next = num[DATA_W-1] ^ c_reg[DATA_W-1];
                    div_cnt_next = DCW'(DW);
                end
            end
            ST_DIV_RUN:
            begin
                div_rem_next = rem_ge ? rem_diff : rem_sh;
                div_dq_next  = {div_dq_reg[DW-2:0], rem_ge};
                div_cnt_next = DCW'(div_cnt_reg - 1'b1);
            end
            ST_COEF:
            begin
                coef_we   = 1'b1;
                coef_next = div_sat;
            end
            ST_MULC:
            begin
                mul_a  = coef_reg;
                mul_b  = p_reg;
                d_next = fx_sub(q_reg, xi_reg);
            end
            ST_FX:
            begin
                fx_next = fx_add(fx_reg, fx_rnd(prod_reg));
                mul_a   = p_reg;
                mul_b   = d_reg;
            end
            ST_PUPD:
            begin
                p_next         = fx_rnd(prod_reg);
                i_next         = CW'(i_reg + 1'b1);
                pt_raddr       = i_next[IW-1:0];
                res_value_next = fx_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = res_value_reg;
            out_status_next = res_status_reg;
        end
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (pt_we)
            pt_mem[pt_waddr] <= pt_wdata;
        pt_q_reg <= pt_mem[pt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[coef_waddr] <= coef_wdata;
        coef_q_reg <= coef_mem[coef_raddr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            ovf_hold_reg  <= 1'b0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            ovf_hold_reg  <= ovf_hold_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        q_reg          <= q_next;
        xi_reg         <= xi_next;
        yi_reg         <= yi_next;
        acc_reg        <= acc_next;
        c_reg          <= c_next;
        d_reg          <= d_next;
        fx_reg         <= fx_next;
        p_reg          <= p_next;
        coef_reg       <= coef_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        div_rem_reg    <= div_rem_next;
        div_dq_reg     <= div_dq_next;
        div_dv_reg     <= div_dv_next;
        div_neg_reg    <= div_neg_next;
        prod_reg       <= mul_a * mul_b;
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_eval_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && cmd.func == FUNC_EVAL) |=> (count_reg == '0 && !ovf_reg))
        else $error("evaluate did not clear point set");

    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (div_cnt_reg != '0) |-> (state_reg == ST_DIV_RUN))
        else $error("divider counting outside its state");

    a_dup_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status == STATUS_DUP) |-> (res.value == '0))
        else $error("zero divisor result not zero");

    a_coef_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COEF) |-> (i_reg < n_reg && j_reg == i_reg))
        else $error("coefficient written out of range");

endmodule
